@@ rtl/lkc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Shared types and constants of the LRU key/value cache.
// No dependencies; every other file imports this package.
package lkc_pkg;

  localparam int unsigned ACT_W     = 2;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned OUT_W     = 32;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_DELETE = 2'd2
  } action_e;

  // Step a cell takes on a committed request.
  typedef enum logic [1:0] {
    MV_HOLD,
    MV_LOAD,
    MV_PREV,
    MV_NEXT
  } move_e;

  // Reordering applied to the whole row.
  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_FRONT,
    MODE_PUSH,
    MODE_REMOVE
  } mode_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    move_e move;
    logic  drop;
    logic  cmp_en;
  } cell_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/lkc_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channels of the LRU key/value cache: request, response, configuration.
// Depends on lkc_pkg.
interface lkc_req_if import lkc_pkg::*; #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic [ACT_W-1:0]      action;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value_in;

  modport source (output valid, action, key, value_in, input ready);
  modport sink   (input valid, action, key, value_in, output ready);
endinterface

interface lkc_rsp_if import lkc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             found;
  logic [OUT_W-1:0] value_out;
  logic             evicted;
  logic [OUT_W-1:0] evicted_key;

  modport source (output valid, found, value_out, evicted, evicted_key, input ready);
  modport sink   (input valid, found, value_out, evicted, evicted_key, output ready);
endinterface

interface lkc_cfg_if import lkc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CAP_W-1:0] capacity;

  modport source (output valid, capacity, input ready);
  modport sink   (input valid, capacity, output ready);
endinterface
`default_nettype wire

@@ rtl/lkc_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// One entry of the recency-ordered row: key, value, valid and a key comparator.
// Depends on lkc_pkg.
module lkc_cell import lkc_pkg::*; #(
  parameter int unsigned KEY_BITS   = 32,
  parameter int unsigned VALUE_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cell_ctrl_t            ctrl_i,
  input  wire logic [KEY_BITS-1:0]   cmp_key_i,
  input  wire logic [KEY_BITS-1:0]   load_key_i,
  input  wire logic [VALUE_BITS-1:0] load_value_i,
  input  wire logic                  prev_valid_i,
  input  wire logic [KEY_BITS-1:0]   prev_key_i,
  input  wire logic [VALUE_BITS-1:0] prev_value_i,
  input  wire logic                  next_valid_i,
  input  wire logic [KEY_BITS-1:0]   next_key_i,
  input  wire logic [VALUE_BITS-1:0] next_value_i,
  output logic                       valid_o,
  output logic [KEY_BITS-1:0]        key_o,
  output logic [VALUE_BITS-1:0]      value_o,
  output logic                       match_o
);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [VALUE_BITS-1:0] value_q, value_d;
  logic                  match_q, match_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    case (ctrl_i.move)
      MV_LOAD: begin
        valid_d = 1'b1;
        key_d   = load_key_i;
        value_d = load_value_i;
      end
      MV_PREV: begin
        valid_d = prev_valid_i & ~ctrl_i.drop;
        key_d   = prev_key_i;
        value_d = prev_value_i;
      end
      MV_NEXT: begin
        valid_d = next_valid_i;
        key_d   = next_key_i;
        value_d = next_value_i;
      end
      default: begin
      end
    endcase
    match_d = ctrl_i.cmp_en ? (valid_q && (key_q == cmp_key_i)) : match_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      match_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      match_q <= match_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign value_o = value_q;
  assign match_o = match_q;

endmodule
`default_nettype wire

@@ rtl/lru_key_value_cache.sv @@
`timescale 1ns / 1ps
`default_nettype none
// LRU key/value cache built as a row of MAX_ENTRIES cells kept in recency order:
// cell 0 holds the most recent entry, the last valid cell the least recent.
//
// Channels: req_i takes a word {action, key, value_in}; rsp_o returns one word
// {found, value_out, evicted, evicted_key} per request; cfg_i writes the
// capacity register and is always ready. Write cfg_i only while idle.
//
// Timing: a request is accepted in the idle cycle; every cell compares its key
// against the request at that edge. In the exec state, once the response slot is free,
// the move-to-front, push or removal is committed across the row and the response
// register is loaded. A new request is accepted only in the idle state.
//
// Stalls: the next request is taken while a response still waits; its commit
// cycle then holds until the pending response is taken.
// Reset: all cells invalid, count zero, capacity 64; no clearing pass.
module lru_key_value_cache import lkc_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64,
  parameter int unsigned KEY_BITS    = 32,
  parameter int unsigned VALUE_BITS  = 32
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  lkc_cfg_if.sink   cfg_i,
  lkc_req_if.sink   req_i,
  lkc_rsp_if.source rsp_o
);

  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_ENTRIES);

  // Configuration
  logic [CAP_W-1:0] capacity_q, capacity_d;

  // Control
  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              req_fire, exec_fire;

  // Request hold registers
  logic [ACT_W-1:0]      action_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;

  // Response register
  logic             rsp_valid_q, rsp_valid_d;
  logic             found_q, found_d;
  logic [OUT_W-1:0] vout_q, vout_d;
  logic             evicted_q, evicted_d;
  logic [OUT_W-1:0] evkey_q, evkey_d;

  // Row
  cell_ctrl_t            ctrl_w  [MAX_ENTRIES];
  logic [KEY_BITS-1:0]   key_w   [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] value_w [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid_w, match_w, below_w, above_w, tail_w;

  logic                  hit, full, evict;
  logic [VALUE_BITS-1:0] hit_value, load_value;
  logic [KEY_BITS-1:0]   tail_key;
  logic [CMP_W-1:0]      eff_cap;
  mode_e                 mode;

  assign cfg_i.ready = 1'b1;
  assign capacity_d  = (cfg_i.valid && cfg_i.ready) ? cfg_i.capacity : capacity_q;

  assign req_fire  = req_i.valid && req_i.ready;
  assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);

  // Next state: take a word when idle, commit it once the response slot frees.
  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Match position prefixes: below_w[i] = match at i or deeper, above_w[i] = at i or shallower.
  always_comb begin
    below_w = match_w;
    above_w = match_w;
    for (int d = 1; d < MAX_ENTRIES; d = d * 2) begin
      below_w = below_w | (below_w >> d);
      above_w = above_w | (above_w << d);
    end
  end

  // Tail is the least recent valid cell; valid cells form a contiguous run from cell 0.
  assign tail_w = valid_w & ~(valid_w >> 1);
  assign hit    = |match_w;

  always_comb begin
    hit_value = '0;
    tail_key  = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (match_w[i]) begin
        hit_value = hit_value | value_w[i];
      end
      if (tail_w[i]) begin
        tail_key = tail_key | key_w[i];
      end
    end
  end

  // Capacity zero acts as one, above the row size saturates.
  always_comb begin
    if (capacity_q == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity_q) > MAX_CMP) begin
      eff_cap = MAX_CMP;
    end else begin
      eff_cap = CMP_W'(capacity_q);
    end
  end

  assign full = (CMP_W'(count_q) >= eff_cap) || (CMP_W'(count_q) >= MAX_CMP);

  // Decode the held request into a row reordering and the response word.
  always_comb begin
    mode       = MODE_NONE;
    evict      = 1'b0;
    load_value = value_q;
    found_d    = 1'b0;
    vout_d     = '0;
    evicted_d  = 1'b0;
    evkey_d    = '0;
    case (action_q)
      ACT_LOOKUP: begin
        found_d    = hit;
        load_value = hit_value;
        if (hit) begin
          mode   = MODE_FRONT;
          vout_d = OUT_W'(hit_value);
        end
      end
      ACT_INSERT: begin
        found_d = hit;
        vout_d  = OUT_W'(value_q);
        if (hit) begin
          mode = MODE_FRONT;
        end else begin
          mode      = MODE_PUSH;
          evict     = full;
          evicted_d = full;
          evkey_d   = full ? OUT_W'(tail_key) : '0;
        end
      end
      ACT_DELETE: begin
        found_d = hit;
        if (hit) begin
          mode = MODE_REMOVE;
        end
      end
      default: begin
      end
    endcase
  end

  // Per-cell steps: front moves the hit to cell 0, push shifts everything down,
  // remove closes the gap from below.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      ctrl_w[i].move   = MV_HOLD;
      ctrl_w[i].drop   = 1'b0;
      ctrl_w[i].cmp_en = req_fire;
    end
    if (exec_fire) begin
      case (mode)
        MODE_FRONT: begin
          ctrl_w[0].move = MV_LOAD;
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            if (below_w[i]) begin
              ctrl_w[i].move = MV_PREV;
            end
          end
        end
        MODE_PUSH: begin
          ctrl_w[0].move = MV_LOAD;
          for (int i = 1; i < MAX_ENTRIES; i++) begin
            ctrl_w[i].move = MV_PREV;
            ctrl_w[i].drop = evict & tail_w[i-1];
          end
        end
        MODE_REMOVE: begin
          for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (above_w[i]) begin
              ctrl_w[i].move = MV_NEXT;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    count_d = count_q;
    if (exec_fire) begin
      if (mode == MODE_PUSH && !evict) begin
        count_d = count_q + CNT_W'(1);
      end else if (mode == MODE_REMOVE) begin
        count_d = count_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (exec_fire) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
  end

  for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
    logic                  prev_valid, next_valid;
    logic [KEY_BITS-1:0]   prev_key, next_key;
    logic [VALUE_BITS-1:0] prev_value, next_value;

    if (g == 0) begin : g_head
      assign prev_valid = 1'b0;
      assign prev_key   = '0;
      assign prev_value = '0;
    end else begin : g_body
      assign prev_valid = valid_w[g-1];
      assign prev_key   = key_w[g-1];
      assign prev_value = value_w[g-1];
    end

    if (g == MAX_ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
      assign next_key   = '0;
      assign next_value = '0;
    end else begin : g_inner
      assign next_valid = valid_w[g+1];
      assign next_key   = key_w[g+1];
      assign next_value = value_w[g+1];
    end

    lkc_cell #(
      .KEY_BITS  (KEY_BITS),
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_w[g]),
      .cmp_key_i   (req_i.key),
      .load_key_i  (key_q),
      .load_value_i(load_value),
      .prev_valid_i(prev_valid),
      .prev_key_i  (prev_key),
      .prev_value_i(prev_value),
      .next_valid_i(next_valid),
      .next_key_i  (next_key),
      .next_value_i(next_value),
      .valid_o     (valid_w[g]),
      .key_o       (key_w[g]),
      .value_o     (value_w[g]),
      .match_o     (match_w[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      capacity_q  <= CAP_RESET;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      capacity_q  <= capacity_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Hold the request word; load the response word on commit.
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      action_q <= req_i.action;
      key_q    <= req_i.key;
      value_q  <= req_i.value_in;
    end
    if (exec_fire) begin
      found_q   <= found_d;
      vout_q    <= vout_d;
      evicted_q <= evicted_d;
      evkey_q   <= evkey_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.found       = found_q;
  assign rsp_o.value_out   = vout_q;
  assign rsp_o.evicted     = evicted_q;
  assign rsp_o.evicted_key = evkey_q;

`ifndef SYNTHESIS
  // Keys are unique among valid cells, so at most one cell matches.
  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_w))
    else $error("more than one cell matches the request key");

  // Valid cells form one run starting at cell 0.
  a_valid_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & (valid_w + MAX_ENTRIES'(1))) == '0)
    else $error("valid cells are not contiguous from the head");

  // The entry count tracks the number of valid cells.
  a_count_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_w) == int'(count_q))
    else $error("entry count disagrees with valid cells");
`endif

endmodule
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of lru_key_value_cache: drives request and capacity
// words and checks every response against a recency-ordered cache predictor.
// Depends on lkc_pkg, the lkc_*_if channel interfaces and the cache RTL.
module tb_top;
  import lkc_pkg::*;

  localparam int unsigned SLOTS      = 64;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned POOL_SIZE  = 128;
  localparam int unsigned LONG_HOLD  = 400;

  // Action code outside the enum; the block must answer it with an all-zero word.
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]      action;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } req_word_t;

  typedef struct packed {
    logic             found;
    logic [OUT_W-1:0] value_out;
    logic             evicted;
    logic [OUT_W-1:0] evicted_key;
  } rsp_word_t;

  logic clk_i;
  logic rst_ni;

  lkc_req_if #(.KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)) req_if ();
  lkc_rsp_if rsp_if ();
  lkc_cfg_if cfg_if ();

  lru_key_value_cache #(
    .MAX_ENTRIES(SLOTS),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Cache predictor: one slot per entry, rank 0 is the most recent entry and
  // fill-1 the least recent one.
  // ---------------------------------------------------------------------------
  logic [KEY_BITS-1:0]   cache_keys [SLOTS];
  logic [VALUE_BITS-1:0] cache_vals [SLOTS];
  logic                  cache_live [SLOTS];
  int unsigned           cache_age  [SLOTS];
  int unsigned           cache_fill;
  logic [CAP_W-1:0]      cache_cap;

  function automatic int locate_key(logic [KEY_BITS-1:0] k);
    for (int i = 0; i < SLOTS; i++)
      if (cache_live[i] && cache_keys[i] == k) return i;
    return -1;
  endfunction

  // Move a slot to the front; everything that was more recent ages by one.
  function automatic void promote_slot(int s);
    int unsigned r;
    r = cache_age[s];
    for (int i = 0; i < SLOTS; i++)
      if (cache_live[i] && cache_age[i] < r) cache_age[i]++;
    cache_age[s] = 0;
  endfunction

  // Free a slot; everything that was less recent moves up by one.
  function automatic void drop_slot(int s);
    int unsigned r;
    r = cache_age[s];
    cache_live[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++)
      if (cache_live[i] && cache_age[i] > r) cache_age[i]--;
    if (cache_fill > 0) cache_fill--;
  endfunction

  function automatic int stalest_slot();
    int best;
    best = -1;
    for (int i = 0; i < SLOTS; i++)
      if (cache_live[i] && (best < 0 || cache_age[i] > cache_age[best])) best = i;
    return best;
  endfunction

  function automatic rsp_word_t predict_response(req_word_t w);
    rsp_word_t   r;
    int          s;
    int          old;
    int          free_s;
    int unsigned limit;
    r = '0;
    s = locate_key(w.key);
    // Capacity zero acts as one; anything above the slot count saturates.
    limit = (cache_cap == 0) ? 1 : (cache_cap > SLOTS) ? SLOTS : cache_cap;
    case (w.action)
      ACT_LOOKUP: begin
        if (s >= 0) begin
          r.found     = 1'b1;
          r.value_out = cache_vals[s];
          promote_slot(s);
        end
      end
      ACT_INSERT: begin
        if (s >= 0) begin
          // Update in place: no eviction, even when full.
          r.found       = 1'b1;
          cache_vals[s] = w.value;
          promote_slot(s);
        end else begin
          // A lowered capacity still evicts exactly one entry per new key.
          if (cache_fill >= limit) begin
            old = stalest_slot();
            if (old >= 0) begin
              r.evicted     = 1'b1;
              r.evicted_key = cache_keys[old];
              drop_slot(old);
            end
          end
          free_s = -1;
          for (int i = 0; i < SLOTS; i++)
            if (!cache_live[i] && free_s < 0) free_s = i;
          if (free_s >= 0) begin
            for (int j = 0; j < SLOTS; j++)
              if (cache_live[j]) cache_age[j]++;
            cache_live[free_s] = 1'b1;
            cache_keys[free_s] = w.key;
            cache_vals[free_s] = w.value;
            cache_age[free_s]  = 0;
            cache_fill++;
          end
        end
        r.value_out = w.value;
      end
      ACT_DELETE: begin
        if (s >= 0) begin
          r.found = 1'b1;
          drop_slot(s);
        end
      end
      default: begin
        // Unused action: state untouched, all-zero response.
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping shared by driver, receiver, monitor and the stimulus thread.
  // ---------------------------------------------------------------------------
  req_word_t   pend_words [$];   // request words waiting to be offered
  rsp_word_t   want_words [$];   // predicted responses, oldest first
  int unsigned words_issued;
  int unsigned words_taken;
  int unsigned mismatches;
  logic        req_taken;        // set at the rising edge, read at the falling one
  logic        rsp_taken;
  logic        rsp_hold_req;     // asks the receiver for one long hold-off
  int          send_gap, send_calm;
  int          recv_gap, recv_calm, recv_hold;
  logic [KEY_BITS-1:0] key_pool [POOL_SIZE];

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s mismatch, got %h want %h", $realtime, field, got, want);
  endtask

  // Mostly back-to-back, a few long gaps, and now and then a calm run of zeros.
  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Driver: present the head word at the falling edge, advance it once taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        void'(pend_words.pop_front());
        send_gap = pick_gap(send_calm);
      end
      if (send_gap > 0) begin
        send_gap--;
        req_if.valid <= 1'b0;
      end else if (pend_words.size() != 0) begin
        req_if.valid    <= 1'b1;
        req_if.action   <= pend_words[0].action;
        req_if.key      <= pend_words[0].key;
        req_if.value_in <= pend_words[0].value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here on request.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_taken) recv_gap = pick_gap(recv_calm);
      if (rsp_hold_req && recv_hold == 0) recv_hold = LONG_HOLD;
      if (recv_hold > 0) begin
        recv_hold--;
        if (recv_hold == 0) rsp_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: check the response first (it always belongs to an older request),
  // then apply a capacity write, then predict the request taken at this edge.
  always @(posedge clk_i) begin
    req_word_t w;
    rsp_word_t want;
    req_taken = rst_ni && req_if.valid && req_if.ready;
    rsp_taken = rst_ni && rsp_if.valid && rsp_if.ready;
    if (rsp_taken) begin
      if (want_words.size() == 0) begin
        report_mismatch("unexpected response", rsp_if.value_out, '0);
      end else begin
        want = want_words.pop_front();
        if (rsp_if.found !== want.found)
          report_mismatch("found", rsp_if.found, want.found);
        if (rsp_if.value_out !== want.value_out)
          report_mismatch("value_out", rsp_if.value_out, want.value_out);
        if (rsp_if.evicted !== want.evicted)
          report_mismatch("evicted", rsp_if.evicted, want.evicted);
        if (rsp_if.evicted_key !== want.evicted_key)
          report_mismatch("evicted_key", rsp_if.evicted_key, want.evicted_key);
      end
    end
    if (rst_ni && cfg_if.valid && cfg_if.ready) cache_cap = cfg_if.capacity;
    if (req_taken) begin
      w.action = req_if.action;
      w.key    = req_if.key;
      w.value  = req_if.value_in;
      want_words.push_back(predict_response(w));
      words_taken++;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers, called from the main thread right after a rising edge.
  // ---------------------------------------------------------------------------
  task automatic queue_word(logic [ACT_W-1:0] act, logic [KEY_BITS-1:0] k,
                            logic [VALUE_BITS-1:0] v);
    req_word_t w;
    w.action = act;
    w.key    = k;
    w.value  = v;
    pend_words.push_back(w);
    words_issued++;
  endtask

  function automatic logic [KEY_BITS-1:0] draw_key(int span);
    if ($urandom_range(99) < 4) return $urandom;
    return key_pool[$urandom_range(span - 1)];
  endfunction

  function automatic logic [VALUE_BITS-1:0] draw_value();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return $urandom;
  endfunction

  // Random mix over the first span pool keys; ins_pct sets how hard it fills.
  task automatic queue_mix(int n, int span, int ins_pct);
    int r;
    logic [ACT_W-1:0] act;
    @(posedge clk_i);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < ins_pct) act = ACT_INSERT;
      else if (r < ins_pct + (100 - ins_pct) * 6 / 10) act = ACT_LOOKUP;
      else if (r < 97) act = ACT_DELETE;
      else act = ACT_UNUSED;
      queue_word(act, draw_key(span), draw_value());
    end
  endtask

  // Hold the sender until every response is back, then let the row settle.
  task automatic wait_quiet();
    while (words_taken != words_issued || want_words.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] cap);
    wait_quiet();
    cfg_if.capacity <= cap;
    cfg_if.valid    <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int span;
    // Known values on every input from time zero.
    rst_ni          = 1'b0;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_LOOKUP;
    req_if.key      = '0;
    req_if.value_in = '0;
    rsp_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.capacity = '0;
    req_taken = 1'b0;
    rsp_taken = 1'b0;
    rsp_hold_req = 1'b0;
    send_gap = 0; send_calm = 0;
    recv_gap = 0; recv_calm = 0; recv_hold = 0;
    words_issued = 0; words_taken = 0; mismatches = 0;
    cache_fill = 0;
    cache_cap  = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      cache_live[i] = 1'b0;
      cache_keys[i] = '0;
      cache_vals[i] = '0;
      cache_age[i]  = 0;
    end
    // Pool keys: both extremes plus random ones, so every key bit toggles.
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-cache misses, extreme keys and values, update in place,
    // the unused action, delete hit then miss.
    set_capacity(7'd64);
    @(posedge clk_i);
    queue_word(ACT_LOOKUP, '0, '1);
    queue_word(ACT_DELETE, '1, '1);
    queue_word(ACT_INSERT, '0, '0);
    queue_word(ACT_INSERT, '1, '1);
    queue_word(ACT_LOOKUP, '0, '1);
    queue_word(ACT_LOOKUP, '1, '0);
    queue_word(ACT_INSERT, '0, 32'hA5A5_A5A5);
    queue_word(ACT_LOOKUP, '0, '0);
    queue_word(ACT_UNUSED, '1, '1);
    queue_word(ACT_DELETE, '0, '1);
    queue_word(ACT_DELETE, '0, '0);
    queue_word(ACT_LOOKUP, '0, '0);
    queue_word(ACT_INSERT, 32'h5A5A_5A5A, 32'h1234_5678);

    // Capacity one below the fill: each new key evicts exactly one entry,
    // while an update of a present key evicts nothing.
    set_capacity(7'd1);
    @(posedge clk_i);
    queue_word(ACT_INSERT, key_pool[2], $urandom);
    queue_word(ACT_INSERT, key_pool[3], $urandom);
    queue_word(ACT_INSERT, key_pool[3], $urandom);
    queue_word(ACT_LOOKUP, key_pool[2], $urandom);
    queue_word(ACT_DELETE, key_pool[3], $urandom);
    queue_word(ACT_DELETE, key_pool[2], $urandom);

    // Capacity zero behaves as one.
    set_capacity(7'd0);
    @(posedge clk_i);
    queue_word(ACT_INSERT, key_pool[4], $urandom);
    queue_word(ACT_INSERT, key_pool[5], $urandom);
    queue_word(ACT_LOOKUP, key_pool[5], $urandom);
    queue_word(ACT_LOOKUP, key_pool[4], $urandom);
    queue_mix(60, 4, 50);

    // Tiny cache, heavy churn.
    set_capacity(7'd2);
    queue_mix(150, 5, 45);

    // Capacity above the slot count saturates: fill past 64 distinct keys,
    // then churn while the receiver holds off long enough to stall the input.
    set_capacity(7'd127);
    @(posedge clk_i);
    for (int i = 0; i < 70; i++) queue_word(ACT_INSERT, key_pool[i], draw_value());
    queue_mix(300, 90, 55);
    @(posedge clk_i);
    rsp_hold_req = 1'b1;

    // Lower the capacity well below the fill; evictions keep the fill level.
    set_capacity(7'd4);
    queue_mix(150, 80, 50);

    // Exact slot count.
    set_capacity(7'd64);
    queue_mix(400, 100, 50);

    // A random mid-range capacity.
    set_capacity(7'($urandom_range(3, 63)));
    span = 3 * cache_cap / 2 + 2;
    queue_mix(200, span, 50);

    // A random over-range capacity, again saturating.
    set_capacity(7'($urandom_range(65, 126)));
    queue_mix(150, 96, 55);

    // Drain, then leave room for any stray response.
    wait_quiet();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("[lru_key_value_cache] OK");
    end else begin
      $display("[lru_key_value_cache] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this sequence.
  initial begin
    #6_000_000;
    $display("[lru_key_value_cache] ERROR");
    $finish;
  end

endmodule
